FILE: hw/rtl/tga_rle_pixel_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - assertion macros
// Shared assertion forms for the checker of the decoder.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH

// checked only out of reset
`define TGA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define TGA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/tgarle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - package
// Types and fixed constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	// register indexes
	localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_IDX_ALPHA  = 2'd2;
	localparam logic [1:0] CFG_IDX_FLIP   = 2'd3;

	localparam logic [12:0] WIDTH_RESET  = 13'd4;
	localparam logic [12:0] HEIGHT_RESET = 13'd1;
	localparam logic [12:0] MIN_WIDTH    = 13'd4;

	// packet header: 128 and up is a run of (h - 127) copies
	localparam logic [7:0] RUN_BIAS = 8'd127;
	localparam logic [2:0] BPP_RGB  = 3'd3;
	localparam logic [2:0] BPP_RGBA = 3'd4;

	// command queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        has_alpha;
		logic        flip_rows;
	} cfg_t;

	// one decoded pixel with its repeat count, or an image restart
	typedef struct packed {
		logic       restart;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] count;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] out_row;
		logic [11:0] out_column;
		logic [7:0]  pixel_count;
		logic        last_of_item;
		logic        image_done;
	} seg_t;

endpackage

FILE: hw/rtl/tgarle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - command queue
// Small register FIFO between the byte parser and the segment splitter.
// ----------------------------------------------------------------------------
module tgarle_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tgarle_pkg::cmd_t  din,
	input  logic              pop,
	output tgarle_pkg::cmd_t  dout,
	output logic              not_empty,
	output logic              full
);

	tgarle_pkg::cmd_t                   mem_q [tgarle_pkg::QUEUE_DEPTH];
	logic [tgarle_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tgarle_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tgarle_pkg::QPTR_W:0]        fill_q;

	logic do_push;
	logic do_pop;

	assign not_empty = (fill_q != '0);
	assign full      = (fill_q == (tgarle_pkg::QPTR_W+1)'(tgarle_pkg::QUEUE_DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/tgarle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - byte parser
// Tracks packet headers, assembles BGR(A) pixels and queues one command per
// finished pixel (count = run length or 1) or per image restart.
// ----------------------------------------------------------------------------
module tgarle_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              op,
	input  logic [7:0]        data_byte,
	input  logic              has_alpha,
	output logic              cmd_push,
	output tgarle_pkg::cmd_t  cmd
);

	logic        exp_hdr_q;
	logic        run_q;
	logic [7:0]  left_q;
	logic [1:0]  bip_q;
	logic [23:0] hold_q;

	logic       accept;
	logic [2:0] bpp;
	logic       last_byte;
	logic [7:0] left_nx;

	assign accept    = in_valid && in_ready;
	assign bpp       = has_alpha ? tgarle_pkg::BPP_RGBA : tgarle_pkg::BPP_RGB;
	assign last_byte = !(({1'b0, bip_q} + 3'd1) < bpp);
	assign cmd_push  = accept && (op || (!exp_hdr_q && last_byte));
	assign left_nx   = run_q ? 8'd0 : ((left_q != 8'd0) ? left_q - 8'd1 : 8'd0);

	always_comb begin
		cmd.restart = op;
		cmd.blue    = hold_q[7:0];
		cmd.green   = hold_q[15:8];
		cmd.red     = has_alpha ? hold_q[23:16] : (hold_q[23:16] | data_byte);
		cmd.alpha   = has_alpha ? data_byte : 8'd0;
		cmd.count   = run_q ? left_q : 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_hdr_q <= 1'b1;
			run_q     <= 1'b0;
			left_q    <= 8'd0;
			bip_q     <= 2'd0;
			hold_q    <= 24'd0;
		end else if (accept) begin
			if (op) begin
				exp_hdr_q <= 1'b1;
				run_q     <= 1'b0;
				left_q    <= 8'd0;
				bip_q     <= 2'd0;
				hold_q    <= 24'd0;
			end else if (exp_hdr_q) begin
				run_q     <= data_byte[7];
				left_q    <= data_byte[7] ? data_byte - tgarle_pkg::RUN_BIAS
				                          : data_byte + 8'd1;
				bip_q     <= 2'd0;
				exp_hdr_q <= 1'b0;
			end else if (!last_byte) begin
				case (bip_q)
					2'd0:    hold_q[7:0]   <= hold_q[7:0] | data_byte;
					2'd1:    hold_q[15:8]  <= hold_q[15:8] | data_byte;
					2'd2:    hold_q[23:16] <= hold_q[23:16] | data_byte;
					default: hold_q        <= hold_q;
				endcase
				bip_q <= bip_q + 2'd1;
			end else begin
				hold_q <= 24'd0;
				bip_q  <= 2'd0;
				left_q <= left_nx;
				if (left_nx == 8'd0) begin
					exp_hdr_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/tgarle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - segment splitter
// Places each queued pixel command in the image, cut at row ends and clipped
// at the image end, one segment per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module tgarle_back #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tgarle_pkg::cfg_t  cfg,
	input  tgarle_pkg::cmd_t  cmd,
	input  logic              cmd_avail,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output tgarle_pkg::seg_t  seg
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
	localparam int unsigned RW    = DIM_W + 1;

	logic [DIM_W-1:0] col_q;
	logic [RW-1:0]    row_q;
	logic             done_q;
	logic             act_q;
	logic [7:0]       want_q;
	tgarle_pkg::cmd_t pix_q;
	logic             out_v_q;
	tgarle_pkg::seg_t seg_q;

	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic             wrap;
	logic [DIM_W-1:0] col_e;
	logic [RW-1:0]    row_e;
	logic             past_end;
	logic [DIM_W-1:0] room;
	logic [7:0]       seg_cnt;
	logic [DIM_W-1:0] col_new;
	logic             end_row;
	logic [RW-1:0]    row_nx;
	logic             fin;
	logic [7:0]       want_n;
	logic             last;
	logic [RW-1:0]    row_out;
	logic             adv;
	logic             emit;

	// clamp the configured size into the supported range
	always_comb begin
		if (cfg.image_width < tgarle_pkg::MIN_WIDTH) begin
			eff_w = DIM_W'(tgarle_pkg::MIN_WIDTH);
		end else if (32'(cfg.image_width) > MAX_DIM) begin
			eff_w = DIM_W'(MAX_DIM);
		end else begin
			eff_w = DIM_W'(cfg.image_width);
		end
		if (cfg.image_height == 13'd0) begin
			eff_h = DIM_W'(1);
		end else if (32'(cfg.image_height) > MAX_DIM) begin
			eff_h = DIM_W'(MAX_DIM);
		end else begin
			eff_h = DIM_W'(cfg.image_height);
		end
	end

	always_comb begin
		wrap     = (col_q >= eff_w);
		col_e    = wrap ? '0 : col_q;
		row_e    = wrap ? row_q + RW'(1) : row_q;
		past_end = (row_e >= RW'(eff_h));
		room     = eff_w - col_e;
		seg_cnt  = (32'(want_q) <= 32'(room)) ? want_q : 8'(room);
		col_new  = col_e + DIM_W'(seg_cnt);
		end_row  = (col_new == eff_w);
		row_nx   = row_e + RW'(1);
		fin      = end_row && (row_nx >= RW'(eff_h));
		want_n   = want_q - seg_cnt;
		last     = (want_n == 8'd0) || fin;
		row_out  = cfg.flip_rows ? RW'(eff_h) - RW'(1) - row_e : row_e;
	end

	assign adv       = !out_v_q || out_ready;
	assign emit      = act_q && !done_q && adv && !past_end;
	assign cmd_pop   = !act_q && cmd_avail;
	assign out_valid = out_v_q;
	assign seg       = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			act_q   <= 1'b0;
			want_q  <= 8'd0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				if (cmd.restart) begin
					col_q  <= '0;
					row_q  <= '0;
					done_q <= 1'b0;
				end else begin
					act_q  <= 1'b1;
					want_q <= cmd.count;
				end
			end else if (act_q) begin
				if (done_q) begin
					// image already full: the command is dropped
					act_q <= 1'b0;
				end else if (adv) begin
					if (past_end) begin
						done_q <= 1'b1;
						act_q  <= 1'b0;
					end else begin
						want_q <= want_n;
						act_q  <= !last;
						done_q <= fin;
						if (end_row) begin
							col_q <= '0;
							row_q <= row_nx;
						end else begin
							col_q <= col_new;
							row_q <= row_e;
						end
					end
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pix_q <= cmd;
		end
		if (emit) begin
			seg_q.red          <= pix_q.red;
			seg_q.green        <= pix_q.green;
			seg_q.blue         <= pix_q.blue;
			seg_q.alpha        <= pix_q.alpha;
			seg_q.out_row      <= 12'(row_out);
			seg_q.out_column   <= 12'(col_e);
			seg_q.pixel_count  <= seg_cnt;
			seg_q.last_of_item <= last;
			seg_q.image_done   <= fin;
		end
	end

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - top level
// Decodes run-length coded TGA pixel data into per-row pixel segments.
// ----------------------------------------------------------------------------
// One coded byte (or an image restart, tuser = 1) is taken per cycle as long as
// the four-entry command queue has room; header bytes and partial pixels queue
// nothing. Every finished pixel becomes one queue command. The segment splitter
// loads a command, then emits one segment per cycle while its output register
// is free or being read: a pixel or run that crosses k row ends yields k + 1
// segments, so a 128-pixel run in a 4-pixel-wide image holds the splitter and
// the input stalls once the queue is full. A segment passes the queue, the
// splitter's command register and the output register after the byte that
// completes its pixel; queued commands and output stalls delay it further. It
// waits in the output register; the input stalls only once the queue is full.
// Segments carry tlast on the last result of the input byte and tuser when the
// image is full; bytes after the image end produce nothing until the next restart.
module tga_rle_pixel_decoder_top #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
	// [43:32] out_row, [55:44] out_column, [63:56] pixel_count
	output logic [63:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser    // [0] image_done
);

	tgarle_pkg::cfg_t cfg_q;
	tgarle_pkg::cmd_t front_cmd;
	tgarle_pkg::cmd_t queue_cmd;
	tgarle_pkg::seg_t seg;
	logic             front_push;
	logic             queue_full;
	logic             queue_avail;
	logic             queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= tgarle_pkg::WIDTH_RESET;
			cfg_q.image_height <= tgarle_pkg::HEIGHT_RESET;
			cfg_q.has_alpha    <= 1'b0;
			cfg_q.flip_rows    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tgarle_pkg::CFG_IDX_WIDTH:  cfg_q.image_width  <= cfg_data;
				tgarle_pkg::CFG_IDX_HEIGHT: cfg_q.image_height <= cfg_data;
				tgarle_pkg::CFG_IDX_ALPHA:  cfg_q.has_alpha    <= cfg_data[0];
				tgarle_pkg::CFG_IDX_FLIP:   cfg_q.flip_rows    <= cfg_data[0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	assign s_tready = !queue_full;

	tgarle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tuser),
		.data_byte (s_tdata),
		.has_alpha (cfg_q.has_alpha),
		.cmd_push  (front_push),
		.cmd       (front_cmd)
	);

	tgarle_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.din       (front_cmd),
		.pop       (queue_pop),
		.dout      (queue_cmd),
		.not_empty (queue_avail),
		.full      (queue_full)
	);

	tgarle_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (queue_cmd),
		.cmd_avail (queue_avail),
		.cmd_pop   (queue_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.seg       (seg)
	);

	assign m_tdata = {seg.pixel_count, seg.out_column, seg.out_row,
	                  seg.alpha, seg.blue, seg.green, seg.red};
	assign m_tlast = seg.last_of_item;
	assign m_tuser = seg.image_done;

endmodule

FILE: hw/rtl/tgarle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - port checker
// Checks the master side of the decoder as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_top_defines.svh"

module tgarle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// a stalled segment keeps its contents
	`TGA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled segment changed")

	// segment length is between 1 and 128 pixels
	`TGA_ASSERT(a_count_range, m_tvalid |-> m_tdata[63:56] != 8'd0 && (!m_tdata[63] || m_tdata[62:56] == 7'd0), "pixel_count out of range")

	// the segment that fills the image is the last one of its transaction
	`TGA_ASSERT(a_done_last, m_tvalid && m_tuser |-> m_tlast, "image_done without tlast")

	// nothing is offered while reset is held
	`TGA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "tvalid during reset")

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: tb/tga_rle_pixel_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - stream checker
// Watches the register port and both stream channels, decodes every accepted
// coded byte with its own copy of the decoder state, and compares each output
// segment in order against the predicted segments.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_checker #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] op
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
	// [43:32] out_row, [55:44] out_column, [63:56] pixel_count
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,   // [0] image_done
	output int          pending,
	output int          fail_count
);

	logic [12:0] reg_width;
	logic [12:0] reg_height;
	logic        reg_alpha;
	logic        reg_flip;

	bit          want_header;
	bit          run_packet;
	bit          image_full;
	int          pix_left;
	logic [1:0]  byte_pos;
	logic [23:0] pix_hold;
	int          col;
	int          row;

	tgarle_pkg::seg_t segments_due[$];

	function automatic int eff_width();
		int w;
		w = int'(reg_width);
		if (w < 4) w = 4;
		if (w > MAX_DIM) w = MAX_DIM;
		return w;
	endfunction

	function automatic int eff_height();
		int h;
		h = int'(reg_height);
		if (h < 1) h = 1;
		if (h > MAX_DIM) h = MAX_DIM;
		return h;
	endfunction

	task automatic clear_decode();
		want_header = 1'b1;
		run_packet  = 1'b0;
		image_full  = 1'b0;
		pix_left    = 0;
		byte_pos    = '0;
		pix_hold    = '0;
		col         = 0;
		row         = 0;
	endtask

	// splits 'copies' identical pixels into per-row segments
	task automatic emit_copies(input int copies, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		int               w;
		int               h;
		int               room;
		int               cnt;
		int               n_new;
		tgarle_pkg::seg_t seg;
		w = eff_width();
		h = eff_height();
		n_new = 0;
		while (copies > 0 && !image_full) begin
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h) begin
				image_full = 1'b1;
				break;
			end
			room = w - col;
			cnt = (copies < room) ? copies : room;
			seg.red          = r;
			seg.green        = g;
			seg.blue         = b;
			seg.alpha        = a;
			seg.out_row      = reg_flip ? 12'(h - 1 - row) : 12'(row);
			seg.out_column   = 12'(col);
			seg.pixel_count  = 8'(cnt);
			seg.last_of_item = 1'b0;
			seg.image_done   = 1'b0;
			copies -= cnt;
			col += cnt;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) begin
					image_full = 1'b1;
					seg.image_done = 1'b1;
				end
			end
			segments_due.push_back(seg);
			n_new++;
		end
		if (n_new > 0) begin
			seg = segments_due.pop_back();
			seg.last_of_item = 1'b1;
			segments_due.push_back(seg);
		end
	endtask

	task automatic decode_byte(input logic restart_req, input logic [7:0] code);
		int          bpp;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic [31:0] shifted;
		bpp = reg_alpha ? 4 : 3;
		if (restart_req) begin
			clear_decode();
			return;
		end
		if (image_full)
			return;
		if (want_header) begin
			run_packet  = (code > tgarle_pkg::RUN_BIAS);
			pix_left    = run_packet ? int'(code) - int'(tgarle_pkg::RUN_BIAS)
			                         : int'(code) + 1;
			byte_pos    = '0;
			want_header = 1'b0;
			return;
		end
		if (int'(byte_pos) + 1 < bpp) begin
			shifted  = {24'b0, code} << (8 * byte_pos);
			pix_hold = pix_hold | shifted[23:0];
			byte_pos = byte_pos + 2'd1;
			return;
		end
		if (reg_alpha) begin
			a = code;
		end else begin
			a = 8'd0;
			pix_hold = pix_hold | {code, 16'b0};
		end
		b = pix_hold[7:0];
		g = pix_hold[15:8];
		r = pix_hold[23:16];
		pix_hold = '0;
		byte_pos = '0;
		if (run_packet) begin
			emit_copies(pix_left, r, g, b, a);
			pix_left = 0;
		end else begin
			emit_copies(1, r, g, b, a);
			pix_left = (pix_left > 0) ? pix_left - 1 : 0;
		end
		if (pix_left == 0)
			want_header = 1'b1;
	endtask

	task automatic check_segment();
		tgarle_pkg::seg_t got;
		tgarle_pkg::seg_t exp_seg;
		got.red          = m_tdata[7:0];
		got.green        = m_tdata[15:8];
		got.blue         = m_tdata[23:16];
		got.alpha        = m_tdata[31:24];
		got.out_row      = m_tdata[43:32];
		got.out_column   = m_tdata[55:44];
		got.pixel_count  = m_tdata[63:56];
		got.last_of_item = m_tlast;
		got.image_done   = m_tuser;
		if (segments_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected segment: rgba %h %h %h %h row %0d col %0d cnt %0d",
					$realtime, got.red, got.green, got.blue, got.alpha, got.out_row,
					got.out_column, got.pixel_count);
		end else begin
			exp_seg = segments_due.pop_front();
			if (got !== exp_seg) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: segment mismatch", $realtime);
					$display("  expected rgba %h %h %h %h row %0d col %0d cnt %0d last %b done %b",
						exp_seg.red, exp_seg.green, exp_seg.blue, exp_seg.alpha,
						exp_seg.out_row, exp_seg.out_column, exp_seg.pixel_count,
						exp_seg.last_of_item, exp_seg.image_done);
					$display("  actual   rgba %h %h %h %h row %0d col %0d cnt %0d last %b done %b",
						got.red, got.green, got.blue, got.alpha, got.out_row,
						got.out_column, got.pixel_count, got.last_of_item, got.image_done);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_width  = tgarle_pkg::WIDTH_RESET;
			reg_height = tgarle_pkg::HEIGHT_RESET;
			reg_alpha  = 1'b0;
			reg_flip   = 1'b0;
			clear_decode();
			segments_due.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tgarle_pkg::CFG_IDX_WIDTH:  reg_width  = cfg_data;
					tgarle_pkg::CFG_IDX_HEIGHT: reg_height = cfg_data;
					tgarle_pkg::CFG_IDX_ALPHA:  reg_alpha  = cfg_data[0];
					tgarle_pkg::CFG_IDX_FLIP:   reg_flip   = cfg_data[0];
					default: ;
				endcase
			end
			// a segment never leaves in the cycle its byte is taken
			if (s_tvalid && s_tready)
				decode_byte(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_segment();
			pending = segments_due.size();
		end
	end

endmodule

FILE: tb/tga_rle_pixel_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - testbench top
// Drives coded TGA pixel streams (literal and run packets, restarts, stray
// bytes, broken packets) under changing image geometry and pixel formats, with
// random gaps on both stream sides; the checker predicts and compares segments.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_tb;

	localparam int unsigned MAX_DIM = 4096;
	localparam logic OP_DATA    = 1'b0;
	localparam logic OP_RESTART = 1'b1;
	localparam int IDLE_MAX     = 17;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 90;
	localparam int PHASE_ITEMS  = 15;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] op
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
	// [43:32] out_row, [55:44] out_column, [63:56] pixel_count
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;   // [0] image_done

	int pending;
	int fail_count;

	bit tx_burst;
	bit rx_burst;
	int items_sent;
	int cur_w;
	int cur_h;
	bit cur_alpha;
	int pix_todo;

	tga_rle_pixel_decoder_top #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	tga_rle_pixel_decoder_checker #(
		.MAX_DIM(MAX_DIM)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.pending   (pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// segment sink: random stall before each transaction, with burst stretches
	initial begin
		int gap;
		m_tready = 1'b0;
		rx_burst = 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, IDLE_MAX);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	task automatic send_item(input logic op, input logic [7:0] code);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [12:0] value);
		int v;
		v = int'(value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			tgarle_pkg::CFG_IDX_WIDTH:
				cur_w = (v < 4) ? 4 : ((v > MAX_DIM) ? MAX_DIM : v);
			tgarle_pkg::CFG_IDX_HEIGHT:
				cur_h = (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
			tgarle_pkg::CFG_IDX_ALPHA:
				cur_alpha = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic restart_image();
		send_item(OP_RESTART, 8'($urandom_range(0, 255)));
		pix_todo = cur_w * cur_h;
	endtask

	task automatic send_pixel();
		int i;
		for (i = 0; i < (cur_alpha ? 4 : 3); i++)
			send_item(OP_DATA, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_run(input int n);
		send_item(OP_DATA, 8'(int'(tgarle_pkg::RUN_BIAS) + n));
		send_pixel();
		pix_todo -= n;
	endtask

	task automatic send_literal(input int n);
		int i;
		send_item(OP_DATA, 8'(n - 1));
		for (i = 0; i < n; i++)
			send_pixel();
		pix_todo -= n;
	endtask

	task automatic random_packet();
		int pick;
		int n;
		int i;
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			send_literal($urandom_range(1, 6));
		end else if (pick < 16) begin
			n = (pick == 15) ? 128 : $urandom_range(1, 2 * cur_w + 2);
			send_run((n > 128) ? 128 : n);
		end else if (pick < 18) begin
			// stray byte: shifts the packet framing
			send_item(OP_DATA, 8'($urandom_range(0, 255)));
		end else begin
			// packet cut off mid-pixel by a restart
			send_item(OP_DATA, 8'($urandom_range(0, 255)));
			n = $urandom_range(0, cur_alpha ? 3 : 2);
			for (i = 0; i < n; i++)
				send_item(OP_DATA, 8'($urandom_range(0, 255)));
			restart_image();
		end
	endtask

	task automatic run_phase(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if (pix_todo <= 0) begin
				if ($urandom_range(0, 2) == 0) begin
					send_item(OP_DATA, 8'($urandom_range(0, 255)));
					items_sent--;   // ignored past the image end
				end
				restart_image();
			end
			random_packet();
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int i;
		int pick;
		int rand_stop;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_DATA;
		tx_burst   = 1'b0;
		items_sent = 0;
		cur_w      = int'(tgarle_pkg::WIDTH_RESET);
		cur_h      = int'(tgarle_pkg::HEIGHT_RESET);
		cur_alpha  = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: 4 x 1, BGR
		send_item(OP_DATA, 8'h00);               // literal of one pixel
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hff);
		send_item(OP_DATA, 8'h80);
		send_item(OP_DATA, 8'hff);               // 128-copy run, clipped at image end
		send_item(OP_DATA, 8'h12);
		send_item(OP_DATA, 8'h34);
		send_item(OP_DATA, 8'h56);
		send_item(OP_DATA, 8'hab);               // past the image end
		send_item(OP_DATA, 8'h00);
		send_item(OP_RESTART, 8'hff);
		send_item(OP_DATA, 8'h01);               // literal of two pixels
		send_item(OP_DATA, 8'h01);
		send_item(OP_DATA, 8'h02);
		send_item(OP_DATA, 8'h03);
		send_item(OP_DATA, 8'hfe);
		send_item(OP_DATA, 8'hfd);
		send_item(OP_DATA, 8'hfc);
		send_item(OP_DATA, 8'(tgarle_pkg::RUN_BIAS + 8'd1)); // run of one
		send_item(OP_DATA, 8'h55);
		send_item(OP_DATA, 8'haa);
		send_item(OP_DATA, 8'h55);
		send_item(OP_DATA, 8'h02);               // literal broken by a restart
		send_item(OP_DATA, 8'h11);
		send_item(OP_RESTART, 8'h00);
		drain();

		// widest row: width above the maximum, full row of 128-copy runs
		set_reg(tgarle_pkg::CFG_IDX_WIDTH, 13'h1fff);
		set_reg(tgarle_pkg::CFG_IDX_HEIGHT, 13'd1);
		set_reg(tgarle_pkg::CFG_IDX_ALPHA, 13'd0);
		set_reg(tgarle_pkg::CFG_IDX_FLIP, 13'd1);
		cfg_we <= 1'b0;
		tx_burst = 1'b1;
		restart_image();
		for (i = 0; i < 32; i++)
			send_run(128);
		drain();

		// tallest image, bottom-up, BGRA, width below the minimum
		set_reg(tgarle_pkg::CFG_IDX_WIDTH, 13'd0);
		set_reg(tgarle_pkg::CFG_IDX_HEIGHT, 13'h1fff);
		set_reg(tgarle_pkg::CFG_IDX_ALPHA, 13'd1);
		cfg_we <= 1'b0;
		tx_burst = 1'b0;
		restart_image();
		run_phase(30);
		drain();

		rand_stop = items_sent + RANDOM_ITEMS;
		while (items_sent < rand_stop) begin
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 3) != 0)
				set_reg(tgarle_pkg::CFG_IDX_WIDTH,
					(pick == 0) ? 13'($urandom_range(0, 3)) : 13'($urandom_range(4, 12)));
			if ($urandom_range(0, 3) != 0)
				set_reg(tgarle_pkg::CFG_IDX_HEIGHT, 13'($urandom_range(0, 4)));
			if ($urandom_range(0, 1) != 0)
				set_reg(tgarle_pkg::CFG_IDX_ALPHA, 13'($urandom_range(0, 1)));
			if ($urandom_range(0, 1) != 0)
				set_reg(tgarle_pkg::CFG_IDX_FLIP, 13'($urandom_range(0, 1)));
			cfg_we <= 1'b0;
			tx_burst = ($urandom_range(0, 3) == 0);
			// otherwise the new geometry applies mid-image
			if ($urandom_range(0, 3) != 0)
				restart_image();
			run_phase(PHASE_ITEMS);
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
